// ----- rtl/core/drum_step_sequencer_top_assert.svh -----
// Assertion macros used by the sequencer port checker.
`ifndef DRUM_STEP_SEQUENCER_TOP_ASSERT_SVH
`define DRUM_STEP_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define DSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define DSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/dss_pkg.sv -----
// Shared types, widths and constants for the drum step sequencer.
`timescale 1ns / 1ps

package dss_pkg;

    localparam int TRACK_COUNT_DEF = 4;
    localparam int STEP_COUNT_DEF  = 16;

    // Fixed field widths of the streams
    localparam int OPCODE_W        = 4;
    localparam int TRK_FIELD_W     = 2;
    localparam int STP_FIELD_W     = 4;
    localparam int MASK_FIELD_W    = 4;
    localparam int PATTERN_FIELD_W = 16;
    localparam int BEAT_RATE_W     = 10;
    localparam int PERIOD_W        = 14;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = OPCODE_W;
    localparam int M_TDATA_W = 40;

    // Input word layout (s_tdata)
    localparam int IN_TRK_LSB  = 0;
    localparam int IN_STP_LSB  = 2;
    localparam int IN_BUSY_BIT = 6;

    // Result word layout (m_tdata)
    localparam int OUT_HIT_VALID_BIT = 0;
    localparam int OUT_HIT_TRACK_LSB = 1;
    localparam int OUT_STEP_POS_LSB  = 3;
    localparam int OUT_PLAYING_BIT   = 7;
    localparam int OUT_CHOSEN_TRK_LSB = 8;
    localparam int OUT_CHOSEN_STP_LSB = 10;
    localparam int OUT_MASK_LSB      = 14;
    localparam int OUT_PATTERN_LSB   = 18;

    localparam int MS_PER_MINUTE   = 60000;
    localparam int PERIOD_DIVIDEND = MS_PER_MINUTE / 4;
    localparam int BEAT_RATE_RESET = 120;

    localparam logic [PERIOD_W-1:0] PERIOD_DIVIDEND_V   = PERIOD_W'(PERIOD_DIVIDEND);
    localparam logic [PERIOD_W-1:0] STEP_PERIOD_RESET_V =
        PERIOD_W'(PERIOD_DIVIDEND / BEAT_RATE_RESET);
    localparam logic [31:0]         DEFAULT_PATTERN     = 32'h0000_8888;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK         = 4'd0,
        OP_PLAY         = 4'd1,
        OP_STOP         = 4'd2,
        OP_TOGGLE_PLAY  = 4'd3,
        OP_NEXT_TRACK   = 4'd4,
        OP_PREV_TRACK   = 4'd5,
        OP_NEXT_STEP    = 4'd6,
        OP_PREV_STEP    = 4'd7,
        OP_TOGGLE_STEP  = 4'd8,
        OP_TOGGLE_SEL   = 4'd9,
        OP_ADD_TRACK    = 4'd10,
        OP_DEL_TRACK    = 4'd11
    } opcode_t;

endpackage

// ----- rtl/core/drum_step_sequencer_top.sv -----
// Drum step sequencer: track patterns, transport and tempo divider.
`timescale 1ns / 1ps
//
// Event-driven 16-step drum sequencer with up to TRACK_COUNT tracks.
// Input stream (s_*): one word per event; s_tuser carries the opcode (1 ms
// tick or an edit/transport command), s_tdata the command operands and the
// player busy flag. Every accepted word yields exactly one result word on
// m_* with the hit flag, play position, selection, track mask and the
// pattern of the selected track.
// Flow: an accepted event passes ST_EXEC and then ST_DONE, which loads the
// result into the output register once it is free; an event that walks the
// tracks (step boundary, track select, add, delete) passes ST_SCAN between
// them, visiting one track per cycle through the single pattern read port.
// s_tready is low from accept until the result is loaded into the output
// register, so a new event is taken only after the last result is loaded.
// A write on cfg_wr_en while idle sets the tempo; the step period is then
// computed by a restoring divider, one quotient bit per cycle, during
// which s_tready is low.
// Reset: stopped, position 0, track 0 used with pattern 0x8888, tempo 120.
// A stalled receiver holds the result word in the output register; the
// next event may be accepted meanwhile but its result waits for the slot.

module drum_step_sequencer_top #(
    parameter int TRACK_COUNT = dss_pkg::TRACK_COUNT_DEF,
    parameter int STEP_COUNT  = dss_pkg::STEP_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] target_track, [5:2] target_step, [6] player_busy, [7] zero
    input  logic [dss_pkg::S_TDATA_W-1:0]    s_tdata,
    // [3:0] opcode
    input  logic [dss_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] hit_valid, [2:1] hit_track, [6:3] step_position, [7] is_playing,
    // [9:8] chosen_track, [13:10] chosen_step, [17:14] track_mask,
    // [33:18] chosen_pattern, [39:34] zero
    output logic [dss_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [dss_pkg::BEAT_RATE_W-1:0]  cfg_wr_data
);
    import dss_pkg::*;

    localparam int TRK_W     = $clog2(TRACK_COUNT);
    localparam int STP_W     = $clog2(STEP_COUNT);
    localparam int DIV_CNT_W = $clog2(PERIOD_W);

    localparam logic [TRK_W-1:0]     TRK_LAST = TRK_W'(TRACK_COUNT - 1);
    localparam logic [STP_W-1:0]     STP_LAST = STP_W'(STEP_COUNT - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PERIOD_W - 1);
    localparam logic [STEP_COUNT-1:0] PATTERN_RESET = DEFAULT_PATTERN[STEP_COUNT-1:0];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SCAN_HIT,
        SCAN_FREE,
        SCAN_UP,
        SCAN_DOWN
    } scan_t;

    state_t                 state_reg, state_next;
    scan_t                  scan_reg, scan_next;
    opcode_t                op_reg, op_next;
    logic [TRK_FIELD_W-1:0] tgt_trk_reg, tgt_trk_next;
    logic [STP_FIELD_W-1:0] tgt_stp_reg, tgt_stp_next;
    logic                   busy_reg, busy_next;

    logic                   run_reg, run_next;
    logic [STP_W-1:0]       pos_reg, pos_next;
    logic [PERIOD_W-1:0]    tick_reg, tick_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [TRACK_COUNT-1:0] used_reg, used_next;
    logic [STEP_COUNT-1:0]  pattern_reg [TRACK_COUNT];
    logic [TRK_W-1:0]       sel_reg, sel_next;
    logic [STP_W-1:0]       edit_reg, edit_next;
    logic [TRK_W-1:0]       cur_reg, cur_next;
    logic                   hit_reg, hit_next;
    logic [TRK_W-1:0]       hit_trk_reg, hit_trk_next;

    logic [BEAT_RATE_W-1:0] bpm_reg, bpm_next;
    logic [PERIOD_W-1:0]    quo_reg, quo_next;
    logic [BEAT_RATE_W-1:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // Single pattern write and read port
    logic                   pat_wr_en;
    logic [TRK_W-1:0]       pat_wr_idx;
    logic [STEP_COUNT-1:0]  pat_wr_data;
    logic [TRK_W-1:0]       rd_idx;
    logic [STEP_COUNT-1:0]  rd_pat;

    function automatic logic [TRK_W-1:0] trk_inc(input logic [TRK_W-1:0] x);
        return (x == TRK_LAST) ? '0 : x + TRK_W'(1);
    endfunction

    function automatic logic [TRK_W-1:0] trk_dec(input logic [TRK_W-1:0] x);
        return (x == '0) ? TRK_LAST : x - TRK_W'(1);
    endfunction

    function automatic logic [STP_W-1:0] stp_inc(input logic [STP_W-1:0] x);
        return (x == STP_LAST) ? '0 : x + STP_W'(1);
    endfunction

    function automatic logic [STP_W-1:0] stp_dec(input logic [STP_W-1:0] x);
        return (x == '0) ? STP_LAST : x - STP_W'(1);
    endfunction

    assign rd_pat   = pattern_reg[rd_idx];
    assign s_tready = (state_reg == ST_IDLE) && !cfg_wr_en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        logic [31:0]            tt_wide;
        logic [31:0]            ts_wide;
        logic [TRK_W-1:0]       flip_trk;
        logic [STP_W-1:0]       flip_stp;
        logic                   flip_ok;
        logic [PERIOD_W-1:0]    tick_inc;
        logic [TRK_W-1:0]       cand;
        logic [BEAT_RATE_W:0]   rem_sh;
        logic                   q_bit;
        logic [31:0]            pos_w, hit_trk_w, sel_w, edit_w, used_w, pat_w;

        state_next    = state_reg;
        scan_next     = scan_reg;
        op_next       = op_reg;
        tgt_trk_next  = tgt_trk_reg;
        tgt_stp_next  = tgt_stp_reg;
        busy_next     = busy_reg;
        run_next      = run_reg;
        pos_next      = pos_reg;
        tick_next     = tick_reg;
        period_next   = period_reg;
        used_next     = used_reg;
        sel_next      = sel_reg;
        edit_next     = edit_reg;
        cur_next      = cur_reg;
        hit_next      = hit_reg;
        hit_trk_next  = hit_trk_reg;
        bpm_next      = bpm_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        pat_wr_en     = 1'b0;
        pat_wr_idx    = sel_reg;
        pat_wr_data   = '0;
        rd_idx        = sel_reg;

        // Toggle-step operands, widened for the range check
        tt_wide  = 32'(tgt_trk_reg);
        ts_wide  = 32'(tgt_stp_reg);
        if (op_reg == OP_TOGGLE_STEP) begin
            flip_trk = tt_wide[TRK_W-1:0];
            flip_stp = ts_wide[STP_W-1:0];
            flip_ok  = (tt_wide < 32'(TRACK_COUNT)) && (ts_wide < 32'(STEP_COUNT));
        end else begin
            flip_trk = sel_reg;
            flip_stp = edit_reg;
            flip_ok  = 1'b1;
        end

        tick_inc = tick_reg + PERIOD_W'(1);
        cand     = (scan_reg == SCAN_DOWN) ? trk_dec(cur_reg) : trk_inc(cur_reg);

        // One restoring-division step: shift in the next dividend bit
        rem_sh = {rem_reg, quo_reg[PERIOD_W-1]};
        q_bit  = (rem_sh >= {1'b0, bpm_reg});

        pos_w     = 32'(pos_reg);
        hit_trk_w = 32'(hit_trk_reg);
        sel_w     = 32'(sel_reg);
        edit_w    = 32'(edit_reg);
        used_w    = 32'(used_reg);
        pat_w     = 32'(rd_pat);

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_wr_en) begin
                    bpm_next     = (cfg_wr_data == '0) ? BEAT_RATE_W'(1) : cfg_wr_data;
                    quo_next     = PERIOD_DIVIDEND_V;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end else if (s_tvalid) begin
                    op_next      = opcode_t'(s_tuser[OPCODE_W-1:0]);
                    tgt_trk_next = s_tdata[IN_TRK_LSB +: TRK_FIELD_W];
                    tgt_stp_next = s_tdata[IN_STP_LSB +: STP_FIELD_W];
                    busy_next    = s_tdata[IN_BUSY_BIT];
                    hit_next     = 1'b0;
                    hit_trk_next = '0;
                    state_next   = ST_EXEC;
                end
            end

            ST_DIV: begin
                if (q_bit) begin
                    rem_next = BEAT_RATE_W'(rem_sh - {1'b0, bpm_reg});
                end else begin
                    rem_next = rem_sh[BEAT_RATE_W-1:0];
                end
                quo_next     = {quo_reg[PERIOD_W-2:0], q_bit};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST) begin
                    period_next = {quo_reg[PERIOD_W-2:0], q_bit};
                    state_next  = ST_IDLE;
                end
            end

            ST_EXEC: begin
                rd_idx     = flip_trk;
                state_next = ST_DONE;
                case (op_reg)
                    OP_TICK: begin
                        if (run_reg) begin
                            if (tick_inc < period_reg) begin
                                tick_next = tick_inc;
                            end else begin
                                // step boundary: walk the tracks from the first
                                tick_next  = '0;
                                cur_next   = '0;
                                scan_next  = SCAN_HIT;
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    OP_PLAY: begin
                        run_next = 1'b1;
                        pos_next = '0;
                    end
                    OP_STOP: begin
                        run_next = 1'b0;
                    end
                    OP_TOGGLE_PLAY: begin
                        run_next = !run_reg;
                        if (!run_reg) begin
                            pos_next = '0;
                        end
                    end
                    OP_NEXT_TRACK: begin
                        cur_next   = sel_reg;
                        scan_next  = SCAN_UP;
                        state_next = ST_SCAN;
                    end
                    OP_PREV_TRACK: begin
                        cur_next   = sel_reg;
                        scan_next  = SCAN_DOWN;
                        state_next = ST_SCAN;
                    end
                    OP_NEXT_STEP: begin
                        edit_next = stp_inc(edit_reg);
                    end
                    OP_PREV_STEP: begin
                        edit_next = stp_dec(edit_reg);
                    end
                    OP_TOGGLE_STEP, OP_TOGGLE_SEL: begin
                        if (flip_ok && used_reg[flip_trk]) begin
                            pat_wr_en   = 1'b1;
                            pat_wr_idx  = flip_trk;
                            pat_wr_data = rd_pat ^ (STEP_COUNT'(1) << flip_stp);
                        end
                    end
                    OP_ADD_TRACK: begin
                        cur_next   = '0;
                        scan_next  = SCAN_FREE;
                        state_next = ST_SCAN;
                    end
                    OP_DEL_TRACK: begin
                        // more than one track in use
                        if ((used_reg & (used_reg - TRACK_COUNT'(1))) != '0) begin
                            used_next[sel_reg] = 1'b0;
                            pat_wr_en   = 1'b1;
                            pat_wr_idx  = sel_reg;
                            pat_wr_data = '0;
                            cur_next    = sel_reg;
                            scan_next   = SCAN_UP;
                            state_next  = ST_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ST_SCAN: begin
                rd_idx = cur_reg;
                unique case (scan_reg)
                    SCAN_HIT: begin
                        if (used_reg[cur_reg] && rd_pat[pos_reg]) begin
                            hit_next     = !busy_reg;
                            hit_trk_next = busy_reg ? '0 : cur_reg;
                            pos_next     = stp_inc(pos_reg);
                            state_next   = ST_DONE;
                        end else if (cur_reg == TRK_LAST) begin
                            pos_next   = stp_inc(pos_reg);
                            state_next = ST_DONE;
                        end else begin
                            cur_next = trk_inc(cur_reg);
                        end
                    end
                    SCAN_FREE: begin
                        if (!used_reg[cur_reg]) begin
                            used_next[cur_reg] = 1'b1;
                            pat_wr_en   = 1'b1;
                            pat_wr_idx  = cur_reg;
                            pat_wr_data = '0;
                            sel_next    = cur_reg;
                            state_next  = ST_DONE;
                        end else if (cur_reg == TRK_LAST) begin
                            state_next = ST_DONE;
                        end else begin
                            cur_next = trk_inc(cur_reg);
                        end
                    end
                    SCAN_UP, SCAN_DOWN: begin
                        // back at the selection: keep it
                        if (cand == sel_reg) begin
                            state_next = ST_DONE;
                        end else if (used_reg[cand]) begin
                            sel_next   = cand;
                            state_next = ST_DONE;
                        end else begin
                            cur_next = cand;
                        end
                    end
                endcase
            end

            ST_DONE: begin
                rd_idx = sel_reg;
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        6'b0,
                        pat_w[PATTERN_FIELD_W-1:0],
                        used_w[MASK_FIELD_W-1:0],
                        edit_w[STP_FIELD_W-1:0],
                        sel_w[TRK_FIELD_W-1:0],
                        run_reg,
                        pos_w[STP_FIELD_W-1:0],
                        hit_trk_w[TRK_FIELD_W-1:0],
                        hit_reg
                    };
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_reg     <= SCAN_HIT;
            run_reg      <= 1'b0;
            pos_reg      <= '0;
            tick_reg     <= '0;
            period_reg   <= STEP_PERIOD_RESET_V;
            used_reg     <= TRACK_COUNT'(1);
            sel_reg      <= '0;
            edit_reg     <= '0;
            cur_reg      <= '0;
            hit_reg      <= 1'b0;
            hit_trk_reg  <= '0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            for (int t = 0; t < TRACK_COUNT; t++) begin
                pattern_reg[t] <= (t == 0) ? PATTERN_RESET : '0;
            end
        end else begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            run_reg      <= run_next;
            pos_reg      <= pos_next;
            tick_reg     <= tick_next;
            period_reg   <= period_next;
            used_reg     <= used_next;
            sel_reg      <= sel_next;
            edit_reg     <= edit_next;
            cur_reg      <= cur_next;
            hit_reg      <= hit_next;
            hit_trk_reg  <= hit_trk_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (pat_wr_en) begin
                pattern_reg[pat_wr_idx] <= pat_wr_data;
            end
        end
        op_reg      <= op_next;
        tgt_trk_reg <= tgt_trk_next;
        tgt_stp_reg <= tgt_stp_next;
        busy_reg    <= busy_next;
        bpm_reg     <= bpm_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ----- rtl/core/dss_checker.sv -----
// Port-level checker for the drum step sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "drum_step_sequencer_top_assert.svh"

module dss_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [dss_pkg::M_TDATA_W-1:0] m_tdata
);
    import dss_pkg::*;

    logic                   hit_valid;
    logic                   is_playing;
    logic [TRK_FIELD_W-1:0] hit_track;

    assign hit_valid  = m_tdata[OUT_HIT_VALID_BIT];
    assign is_playing = m_tdata[OUT_PLAYING_BIT];
    assign hit_track  = m_tdata[OUT_HIT_TRACK_LSB +: TRK_FIELD_W];

    // hold a stalled result word
    `DSS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // one event in flight: ready drops right after an accept
    `DSS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready,
        !s_tready, "second word accepted while an event is in flight")

    `DSS_ASSERT_NOW(a_hit_needs_run, aclk, aresetn, m_tvalid && hit_valid,
        is_playing, "hit reported while transport is stopped")

    `DSS_ASSERT_NOW(a_no_hit_track_zero, aclk, aresetn, m_tvalid && !hit_valid,
        hit_track == '0, "hit track nonzero without a hit")

endmodule

bind drum_step_sequencer_top dss_checker u_dss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/drum_step_checker.sv -----
// Checker that predicts and compares every result word of the step sequencer.
`timescale 1ns / 1ps

module drum_step_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [dss_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [dss_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [dss_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [dss_pkg::BEAT_RATE_W-1:0]  cfg_wr_data,
    output int unsigned                      fail_count,
    output int unsigned                      hit_count,
    output int unsigned                      backlog
);
    import dss_pkg::*;

    localparam int TRACKS = TRACK_COUNT_DEF;
    localparam int MAX_PRINTS = 30;

    typedef struct packed {
        logic                       hit;
        logic [TRK_FIELD_W-1:0]     hit_trk;
        logic [STP_FIELD_W-1:0]     pos;
        logic                       playing;
        logic [TRK_FIELD_W-1:0]     sel;
        logic [STP_FIELD_W-1:0]     edit;
        logic [MASK_FIELD_W-1:0]    mask;
        logic [PATTERN_FIELD_W-1:0] pattern;
    } status_word_t;

    // Sequencer state as the block should hold it
    logic                       running;
    logic [STP_FIELD_W-1:0]     play_pos;
    logic [STP_FIELD_W-1:0]     edit_pos;
    logic [PERIOD_W-1:0]        ms_count;
    logic [PERIOD_W-1:0]        period;
    logic [TRACKS-1:0]          used;
    logic [PATTERN_FIELD_W-1:0] pattern [TRACKS];
    logic [TRK_FIELD_W-1:0]     sel_trk;

    status_word_t status_words_due [$];
    status_word_t next_status;
    int unsigned  words_checked;

    function automatic logic [PERIOD_W-1:0] period_for(logic [BEAT_RATE_W-1:0] bpm);
        int unsigned         b;
        logic [PERIOD_W-1:0] p;
        b = (bpm == '0) ? 32'd1 : 32'(bpm);
        p = PERIOD_W'((MS_PER_MINUTE / b) / 4);
        return p;
    endfunction

    function automatic logic [TRK_FIELD_W-1:0] next_used(logic [TRK_FIELD_W-1:0] start,
                                                         bit upward);
        logic [TRK_FIELD_W-1:0] idx;
        for (int i = 1; i <= TRACKS; i++) begin
            idx = upward ? start + i[TRK_FIELD_W-1:0] : start - i[TRK_FIELD_W-1:0];
            if (used[idx]) return idx;
        end
        return start;
    endfunction

    function automatic void flip_step(logic [TRK_FIELD_W-1:0] trk,
                                      logic [STP_FIELD_W-1:0] stp);
        if (used[trk]) pattern[trk][stp] = ~pattern[trk][stp];
    endfunction

    function automatic void reset_sequencer();
        running  = 1'b0;
        play_pos = '0;
        edit_pos = '0;
        ms_count = '0;
        period   = period_for(BEAT_RATE_W'(BEAT_RATE_RESET));
        used     = '0;
        used[0]  = 1'b1;
        for (int t = 0; t < TRACKS; t++) pattern[t] = '0;
        pattern[0] = DEFAULT_PATTERN[PATTERN_FIELD_W-1:0];
        sel_trk  = '0;
    endfunction

    function automatic status_word_t advance_sequencer(logic [OPCODE_W-1:0] op,
                                                       logic [TRK_FIELD_W-1:0] trk,
                                                       logic [STP_FIELD_W-1:0] stp,
                                                       logic busy);
        status_word_t w;
        logic         found;
        int           live;
        w = '0;
        found = 1'b0;
        live = 0;
        case (op)
            OP_TICK: begin
                if (running) begin
                    ms_count = ms_count + 1'b1;
                    if (ms_count >= period) begin
                        ms_count = '0;
                        // first used track with the bit set wins, even when busy
                        for (int t = 0; t < TRACKS; t++) begin
                            if (!found && used[t] && pattern[t][play_pos]) begin
                                found = 1'b1;
                                if (!busy) begin
                                    w.hit = 1'b1;
                                    w.hit_trk = t[TRK_FIELD_W-1:0];
                                end
                            end
                        end
                        play_pos = play_pos + 1'b1;
                    end
                end
            end
            OP_PLAY: begin
                running = 1'b1;
                play_pos = '0;
            end
            OP_STOP: running = 1'b0;
            OP_TOGGLE_PLAY: begin
                if (running) begin
                    running = 1'b0;
                end else begin
                    running = 1'b1;
                    play_pos = '0;
                end
            end
            OP_NEXT_TRACK:  sel_trk = next_used(sel_trk, 1'b1);
            OP_PREV_TRACK:  sel_trk = next_used(sel_trk, 1'b0);
            OP_NEXT_STEP:   edit_pos = edit_pos + 1'b1;
            OP_PREV_STEP:   edit_pos = edit_pos - 1'b1;
            OP_TOGGLE_STEP: flip_step(trk, stp);
            OP_TOGGLE_SEL:  flip_step(sel_trk, edit_pos);
            OP_ADD_TRACK: begin
                for (int t = 0; t < TRACKS; t++) begin
                    if (!found && !used[t]) begin
                        found = 1'b1;
                        used[t] = 1'b1;
                        pattern[t] = '0;
                        sel_trk = t[TRK_FIELD_W-1:0];
                    end
                end
            end
            OP_DEL_TRACK: begin
                for (int t = 0; t < TRACKS; t++) if (used[t]) live++;
                if (live > 1) begin
                    used[sel_trk] = 1'b0;
                    pattern[sel_trk] = '0;
                    sel_trk = next_used(sel_trk, 1'b1);
                end
            end
            default: ;
        endcase
        w.pos     = play_pos;
        w.playing = running;
        w.sel     = sel_trk;
        w.edit    = edit_pos;
        w.mask    = used;
        w.pattern = pattern[sel_trk];
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        if (fail_count < MAX_PRINTS) $display("%0t ns word %0d: %s", $time, words_checked, msg);
        fail_count++;
    endtask

    task automatic compare_field(string name, logic [PATTERN_FIELD_W-1:0] got,
                                 logic [PATTERN_FIELD_W-1:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task automatic match_status_word(status_word_t want, logic [M_TDATA_W-1:0] word);
        compare_field("hit_valid", PATTERN_FIELD_W'(word[OUT_HIT_VALID_BIT]),
                      PATTERN_FIELD_W'(want.hit));
        compare_field("hit_track", PATTERN_FIELD_W'(word[OUT_HIT_TRACK_LSB +: TRK_FIELD_W]),
                      PATTERN_FIELD_W'(want.hit_trk));
        compare_field("step_position",
                      PATTERN_FIELD_W'(word[OUT_STEP_POS_LSB +: STP_FIELD_W]),
                      PATTERN_FIELD_W'(want.pos));
        compare_field("is_playing", PATTERN_FIELD_W'(word[OUT_PLAYING_BIT]),
                      PATTERN_FIELD_W'(want.playing));
        compare_field("chosen_track",
                      PATTERN_FIELD_W'(word[OUT_CHOSEN_TRK_LSB +: TRK_FIELD_W]),
                      PATTERN_FIELD_W'(want.sel));
        compare_field("chosen_step",
                      PATTERN_FIELD_W'(word[OUT_CHOSEN_STP_LSB +: STP_FIELD_W]),
                      PATTERN_FIELD_W'(want.edit));
        compare_field("track_mask", PATTERN_FIELD_W'(word[OUT_MASK_LSB +: MASK_FIELD_W]),
                      PATTERN_FIELD_W'(want.mask));
        compare_field("chosen_pattern", word[OUT_PATTERN_LSB +: PATTERN_FIELD_W],
                      want.pattern);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_sequencer();
            status_words_due.delete();
            fail_count = 0;
            hit_count = 0;
            words_checked = 0;
        end else begin
            // compare before queuing so a word can never match its own input
            if (m_tvalid && m_tready) begin
                if (status_words_due.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                    match_status_word(status_words_due.pop_front(), m_tdata);
                words_checked++;
            end
            if (cfg_wr_en) period = period_for(cfg_wr_data);
            if (s_tvalid && s_tready) begin
                next_status = advance_sequencer(s_tuser, s_tdata[IN_TRK_LSB +: TRK_FIELD_W],
                                                s_tdata[IN_STP_LSB +: STP_FIELD_W],
                                                s_tdata[IN_BUSY_BIT]);
                if (next_status.hit) hit_count++;
                status_words_due.push_back(next_status);
            end
        end
        backlog = status_words_due.size();
    end

endmodule

// ----- test/tb_drum_step_sequencer_top.sv -----
// Testbench top: event stimulus, result sink and verdict for the step sequencer.
`timescale 1ns / 1ps

module tb_drum_step_sequencer_top;
    import dss_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 4'd12;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 4'd15;
    localparam int LONG_HOLD = 300;
    localparam int HOLD_AT_WORD = 600;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en;
    logic [BEAT_RATE_W-1:0] cfg_wr_data;

    int unsigned fail_count;
    int unsigned hit_count;
    int unsigned backlog;
    int unsigned words_sent;
    int unsigned words_taken;
    int unsigned tempo_changes;
    bit          src_quiet;
    bit          sink_quiet;

    drum_step_sequencer_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    drum_step_checker scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .hit_count   (hit_count),
        .backlog     (backlog)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("run timed out waiting on a handshake");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result sink: random stall after each word, one long hold to back up the input
    initial begin : sink
        int unsigned stall;
        stall = 0;
        words_taken = 0;
        sink_quiet = 1'b0;
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (stall != 0) begin
                stall--;
                if (stall == 0) m_tready <= 1'b1;
            end else if (aresetn && m_tvalid && m_tready) begin
                words_taken++;
                if (words_taken % 40 == 0) sink_quiet = ($urandom_range(0, 2) == 0);
                if (words_taken == HOLD_AT_WORD) stall = LONG_HOLD;
                else stall = sink_quiet ? 0 : $urandom_range(0, 7);
                if (stall != 0) m_tready <= 1'b0;
            end
        end
    end

    task automatic send_event(logic [OPCODE_W-1:0] op, logic [TRK_FIELD_W-1:0] trk,
                              logic [STP_FIELD_W-1:0] stp, logic busy);
        int unsigned gap;
        if (words_sent % 50 == 0) src_quiet = ($urandom_range(0, 2) == 0);
        gap = src_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, busy, stp, trk};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_random();
        int unsigned         roll;
        logic [OPCODE_W-1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 66)      op = OP_TICK;
        else if (roll < 70) op = OP_PLAY;
        else if (roll < 71) op = OP_STOP;
        else if (roll < 73) op = OP_TOGGLE_PLAY;
        else if (roll < 75) op = OP_NEXT_TRACK;
        else if (roll < 77) op = OP_PREV_TRACK;
        else if (roll < 80) op = OP_NEXT_STEP;
        else if (roll < 83) op = OP_PREV_STEP;
        else if (roll < 91) op = OP_TOGGLE_STEP;
        else if (roll < 94) op = OP_TOGGLE_SEL;
        else if (roll < 96) op = OP_ADD_TRACK;
        else if (roll < 98) op = OP_DEL_TRACK;
        else                op = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        send_event(op, TRK_FIELD_W'($urandom_range(0, 3)), STP_FIELD_W'($urandom_range(0, 15)),
                   $urandom_range(0, 3) == 0);
    endtask

    task automatic run_random(int unsigned count);
        repeat (count) send_random();
    endtask

    // Start the transport and let the ms counter climb
    task automatic run_ticks(int unsigned count);
        send_event(OP_PLAY, TRK_FIELD_W'($urandom_range(0, 3)),
                   STP_FIELD_W'($urandom_range(0, 15)), 1'b0);
        repeat (count)
            send_event(OP_TICK, TRK_FIELD_W'($urandom_range(0, 3)),
                       STP_FIELD_W'($urandom_range(0, 15)), $urandom_range(0, 1) == 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (words_taken != words_sent) @(posedge aclk);
    endtask

    task automatic set_tempo(logic [BEAT_RATE_W-1:0] bpm);
        drain();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bpm;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tempo_changes++;
    endtask

    initial begin : stimulus
        logic [BEAT_RATE_W-1:0] bpm;
        words_sent = 0;
        tempo_changes = 0;
        src_quiet = 1'b0;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= OP_TICK;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass at the reset tempo
        send_event(OP_UNUSED_LO, 2'd3, 4'd15, 1'b1);
        send_event(OP_UNUSED_HI, 2'd0, 4'd0, 1'b0);
        send_event(OP_TICK, 2'd0, 4'd0, 1'b0);
        send_event(OP_NEXT_TRACK, 2'd0, 4'd0, 1'b0);
        send_event(OP_PREV_TRACK, 2'd0, 4'd0, 1'b0);
        send_event(OP_PREV_STEP, 2'd0, 4'd0, 1'b0);
        send_event(OP_NEXT_STEP, 2'd0, 4'd0, 1'b0);
        send_event(OP_TOGGLE_STEP, 2'd3, 4'd15, 1'b0);
        send_event(OP_TOGGLE_STEP, 2'd0, 4'd0, 1'b1);
        send_event(OP_TOGGLE_SEL, 2'd0, 4'd0, 1'b0);
        send_event(OP_DEL_TRACK, 2'd0, 4'd0, 1'b0);
        repeat (4) send_event(OP_ADD_TRACK, 2'd0, 4'd0, 1'b0);
        send_event(OP_TOGGLE_STEP, 2'd3, 4'd15, 1'b0);
        send_event(OP_NEXT_TRACK, 2'd0, 4'd0, 1'b0);
        send_event(OP_PREV_TRACK, 2'd0, 4'd0, 1'b0);
        send_event(OP_DEL_TRACK, 2'd0, 4'd0, 1'b0);
        send_event(OP_TOGGLE_PLAY, 2'd0, 4'd0, 1'b0);
        send_event(OP_TOGGLE_PLAY, 2'd0, 4'd0, 1'b0);
        send_event(OP_PLAY, 2'd0, 4'd0, 1'b0);
        send_event(OP_STOP, 2'd0, 4'd0, 1'b0);

        set_tempo(10'd1023);
        run_random(380);
        set_tempo(10'd0);
        run_random(20);
        run_ticks(30);
        // counter left over from the slow tempo fires on the first tick
        set_tempo(10'd1023);
        run_random(380);
        set_tempo(10'd1);
        run_ticks(30);
        set_tempo(10'd120);
        run_random(300);
        set_tempo(10'd1000);
        run_random(300);
        bpm = BEAT_RATE_W'($urandom_range(2, 1023));
        set_tempo(bpm);
        run_random(250);

        drain();
        repeat (20) @(posedge aclk);
        if (backlog != 0) $display("%0d predicted words never came out", backlog);
        $display("Covered %0d events across %0d tempo settings (0, 1, 1023 among them), %0d hits.",
                 words_sent, tempo_changes, hit_count);
        $display("Receiver held off %0d cycles once while events kept arriving.", LONG_HOLD);
        if (fail_count == 0 && backlog == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
